/* hw/rtl/arx_aead_pkg.sv */
// Shared types, constants and round function for the ARX AEAD stream engine
package arx_aead_pkg;

   // Action codes carried by a request item
   localparam logic [2:0] ACT_INIT     = 3'd0;
   localparam logic [2:0] ACT_ABSORB   = 3'd1;
   localparam logic [2:0] ACT_ENCRYPT  = 3'd2;
   localparam logic [2:0] ACT_DECRYPT  = 3'd3;
   localparam logic [2:0] ACT_FINALIZE = 3'd4;

   // Configuration register indexes
   localparam logic [1:0] CSR_KEY_WORD_0 = 2'd0;
   localparam logic [1:0] CSR_KEY_WORD_1 = 2'd1;
   localparam logic [1:0] CSR_KEY_WORD_2 = 2'd2;
   localparam logic [1:0] CSR_KEY_WORD_3 = 2'd3;

   // Update counts for the long actions (last update index)
   localparam logic [4:0] INIT_LAST_UPDATE = 5'd19;
   localparam logic [4:0] FIN_LAST_UPDATE  = 5'd9;

   // Sequencer states
   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_RUN,
      FSM_DONE
   } fsm_type;

   typedef logic [7:0][31:0] lane_const_type;

   localparam lane_const_type ROUND_CONST = {
      32'hc2b3293d, 32'hcfbfa1c8, 32'h4f7c7b57, 32'hbb1185eb,
      32'h324e7738, 32'h38b4da56, 32'hbf715880, 32'hb7e15162 };

   localparam lane_const_type INIT_X = {
      32'hec4e6c89, 32'h082efa98, 32'h299f31d0, 32'ha4093822,
      32'h03707344, 32'h13198a2e, 32'h85a308d3, 32'h243f6a88 };

   localparam lane_const_type INIT_Y = {
      32'hb5470917, 32'h3f84d5b5, 32'hc97c50dd, 32'hc0ac29b7,
      32'h34e90c6c, 32'hbe5466cf, 32'h38d01377, 32'h452821e6 };

   function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
      return (v >> n) | (v << (32 - n));
   endfunction

   // One ARX round of one lane; returns {b, a}
   function automatic logic [63:0] lane_round(input logic [31:0] a_i,
                                              input logic [31:0] b_i,
                                              input logic [31:0] k,
                                              input logic [1:0]  rnd);
      logic [31:0] a;
      logic [31:0] b;
      a = a_i;
      b = b_i;
      case (rnd)
         2'd0: begin
            a = a + rotr(b, 31);
            b = b + rotr(a, 24);
         end
         2'd1: begin
            a = a + rotr(b, 17);
            b = b + rotr(a, 17);
         end
         2'd2: begin
            a = a + b;
            b = b + rotr(a, 31);
         end
         default: begin
            a = a + rotr(b, 24);
            b = b + rotr(a, 16);
         end
      endcase
      a = a ^ k;
      return {b, a};
   endfunction

endpackage

/* hw/rtl/arx_aead_if.sv */
// Request and response channel interfaces of the ARX AEAD stream engine
interface arx_aead_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [63:0] data_lo;
   logic [63:0] data_hi;
   logic [31:0] nonce_tail;
   logic [4:0]  valid_bytes;

   modport source (output valid, action, data_lo, data_hi, nonce_tail, valid_bytes,
                   input ready);
   modport sink (input valid, action, data_lo, data_hi, nonce_tail, valid_bytes,
                 output ready);
endinterface

interface arx_aead_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] result_lo;
   logic [63:0] result_hi;
   logic        tag_match;

   modport source (output valid, result_lo, result_hi, tag_match, input ready);
   modport sink (input valid, result_lo, result_hi, tag_match, output ready);
endinterface

/* hw/rtl/arx_aead_stream_engine.sv */
// ARX AEAD stream engine: 512-bit state, one shared ARX round unit under a sequencer
// Sequence: absorb/encrypt/decrypt run the four ARX rounds of one update, then the done
// state loads the output register; init and finalize repeat updates to their last index.
// Flow: new items are accepted only while the sequencer is idle; rate set by the single
// round unit, which runs one of the four ARX rounds on all eight lanes each cycle.
// Undefined actions return a zero result. Synchronous active-high reset
// clears the state, byte counters, key registers and the sequencer.
module arx_aead_stream_engine (
   input  logic                  clock,
   input  logic                  reset,
   arx_aead_req_if.sink          req_chan,
   arx_aead_rsp_if.source        rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [1:0]            csr_index,
   input  logic [63:0]           csr_wr_data
);

   arx_aead_pkg::fsm_type fsm_ff, fsm_in;

   logic [3:0][63:0] key_ff, key_in;
   logic [7:0][63:0] state_ff, state_in;
   logic [7:0][63:0] prev_ff, prev_in;
   logic [63:0]      ad_cnt_ff, ad_cnt_in;
   logic [63:0]      msg_cnt_ff, msg_cnt_in;
   logic [1:0]       round_ff, round_in;
   logic [4:0]       upd_cnt_ff, upd_cnt_in;
   logic [4:0]       last_ff, last_in;
   logic [2:0]       act_ff, act_in;
   logic [63:0]      hold_lo_ff, hold_lo_in;
   logic [63:0]      hold_hi_ff, hold_hi_in;
   logic [63:0]      pend_lo_ff, pend_lo_in;
   logic [63:0]      pend_hi_ff, pend_hi_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [63:0]      rsp_lo_ff, rsp_lo_in;
   logic [63:0]      rsp_hi_ff, rsp_hi_in;
   logic             rsp_match_ff, rsp_match_in;

   logic             accept;
   logic [4:0]       nv;
   logic [63:0]      mlo, mhi;
   logic [63:0]      klo, khi;
   logic [63:0]      dec_lo, dec_hi;
   logic [255:0]     x_vec, y_vec, xo_vec, yo_vec;
   logic [63:0]      lane_res;
   logic [7:0][63:0] perm_word;
   logic [63:0]      d1, d2;
   logic [63:0]      tag_lo, tag_hi;

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (fsm_ff == arx_aead_pkg::FSM_IDLE);

   // Byte masks from the saturated valid-byte count
   always_comb begin
      nv = (req_chan.valid_bytes > 5'd16) ? 5'd16 : req_chan.valid_bytes;
      for (int b = 0; b < 8; b++) begin
         mlo[8*b +: 8] = {8{(5'(b) < nv)}};
         mhi[8*b +: 8] = {8{(5'(b + 8) < nv)}};
      end
   end

   // Keystream and decrypted block from the present state
   assign klo    = state_ff[2] ^ state_ff[6];
   assign khi    = state_ff[3] ^ state_ff[7];
   assign dec_lo = ((req_chan.data_lo & mlo) ^ klo) & mlo;
   assign dec_hi = ((req_chan.data_hi & mhi) ^ khi) & mhi;

   // Shared round unit: one round on all eight lanes
   assign x_vec = state_ff[3:0];
   assign y_vec = state_ff[7:4];
   always_comb begin
      xo_vec   = '0;
      yo_vec   = '0;
      lane_res = '0;
      for (int j = 0; j < 8; j++) begin
         lane_res = arx_aead_pkg::lane_round(x_vec[32*j +: 32], y_vec[32*j +: 32],
                                             arx_aead_pkg::ROUND_CONST[j], round_ff);
         xo_vec[32*j +: 32] = lane_res[31:0];
         yo_vec[32*j +: 32] = lane_res[63:32];
      end
      perm_word = {yo_vec, xo_vec};
   end

   // Data folded in at the end of each update
   always_comb begin
      case (act_ff)
         arx_aead_pkg::ACT_INIT: begin
            d1 = {59'd0, upd_cnt_ff};
            d2 = {59'd0, upd_cnt_ff};
         end
         arx_aead_pkg::ACT_FINALIZE: begin
            d1 = ad_cnt_ff;
            d2 = msg_cnt_ff;
         end
         default: begin
            d1 = hold_lo_ff;
            d2 = hold_hi_ff;
         end
      endcase
   end

   // Tag from the finished state
   assign tag_lo = state_ff[0] ^ state_ff[2] ^ state_ff[4] ^ state_ff[6];
   assign tag_hi = state_ff[1] ^ state_ff[3] ^ state_ff[5] ^ state_ff[7];

   // Key registers
   always_comb begin
      key_in = key_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            arx_aead_pkg::CSR_KEY_WORD_0: key_in[0] = csr_wr_data;
            arx_aead_pkg::CSR_KEY_WORD_1: key_in[1] = csr_wr_data;
            arx_aead_pkg::CSR_KEY_WORD_2: key_in[2] = csr_wr_data;
            arx_aead_pkg::CSR_KEY_WORD_3: key_in[3] = csr_wr_data;
            default: key_in = key_ff;
         endcase
      end
   end

   // Sequencer: next state and datapath control
   always_comb begin
      fsm_in       = fsm_ff;
      state_in     = state_ff;
      prev_in      = prev_ff;
      ad_cnt_in    = ad_cnt_ff;
      msg_cnt_in   = msg_cnt_ff;
      round_in     = round_ff;
      upd_cnt_in   = upd_cnt_ff;
      last_in      = last_ff;
      act_in       = act_ff;
      hold_lo_in   = hold_lo_ff;
      hold_hi_in   = hold_hi_ff;
      pend_lo_in   = pend_lo_ff;
      pend_hi_in   = pend_hi_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_lo_in    = rsp_lo_ff;
      rsp_hi_in    = rsp_hi_ff;
      rsp_match_in = rsp_match_ff;

      unique case (fsm_ff)
         arx_aead_pkg::FSM_IDLE: begin
            if (accept) begin
               act_in     = req_chan.action;
               round_in   = 2'd0;
               upd_cnt_in = 5'd0;
               last_in    = 5'd0;
               pend_lo_in = '0;
               pend_hi_in = '0;
               fsm_in     = arx_aead_pkg::FSM_RUN;
               unique case (req_chan.action)
                  arx_aead_pkg::ACT_INIT: begin
                     for (int i = 0; i < 4; i++) begin
                        state_in[i]     = {arx_aead_pkg::INIT_X[2*i+1],
                                           arx_aead_pkg::INIT_X[2*i]} ^ key_ff[i];
                        state_in[i + 4] = {arx_aead_pkg::INIT_Y[2*i+1],
                                           arx_aead_pkg::INIT_Y[2*i]};
                     end
                     state_in[4] = state_in[4] ^ req_chan.data_lo;
                     state_in[5] = state_in[5] ^ req_chan.data_hi;
                     state_in[6] = state_in[6] ^ {32'd0, req_chan.nonce_tail};
                     ad_cnt_in   = '0;
                     msg_cnt_in  = '0;
                     last_in     = arx_aead_pkg::INIT_LAST_UPDATE;
                  end
                  arx_aead_pkg::ACT_ABSORB: begin
                     hold_lo_in = req_chan.data_lo & mlo;
                     hold_hi_in = req_chan.data_hi & mhi;
                     ad_cnt_in  = ad_cnt_ff + {59'd0, nv};
                  end
                  arx_aead_pkg::ACT_ENCRYPT: begin
                     hold_lo_in = req_chan.data_lo & mlo;
                     hold_hi_in = req_chan.data_hi & mhi;
                     pend_lo_in = ((req_chan.data_lo & mlo) ^ klo) & mlo;
                     pend_hi_in = ((req_chan.data_hi & mhi) ^ khi) & mhi;
                     msg_cnt_in = msg_cnt_ff + {59'd0, nv};
                  end
                  arx_aead_pkg::ACT_DECRYPT: begin
                     hold_lo_in = dec_lo;
                     hold_hi_in = dec_hi;
                     pend_lo_in = dec_lo;
                     pend_hi_in = dec_hi;
                     msg_cnt_in = msg_cnt_ff + {59'd0, nv};
                  end
                  arx_aead_pkg::ACT_FINALIZE: begin
                     hold_lo_in = req_chan.data_lo;
                     hold_hi_in = req_chan.data_hi;
                     last_in    = arx_aead_pkg::FIN_LAST_UPDATE;
                  end
                  default: begin
                     // undefined action: no update, zero result
                     fsm_in = arx_aead_pkg::FSM_DONE;
                  end
               endcase
            end
         end

         arx_aead_pkg::FSM_RUN: begin
            round_in = round_ff + 2'd1;
            if (round_ff == 2'd0) begin
               prev_in = state_ff;
            end
            if (round_ff == 2'd3) begin
               // feed-forward of the rotated previous state, then the data words
               for (int i = 0; i < 8; i++) begin
                  state_in[i] = perm_word[i] ^ prev_ff[3'(i + 7)];
               end
               state_in[0] = state_in[0] ^ d1;
               state_in[4] = state_in[4] ^ d2;
               upd_cnt_in  = upd_cnt_ff + 5'd1;
               if (upd_cnt_ff == last_ff) begin
                  fsm_in = arx_aead_pkg::FSM_DONE;
               end
            end else begin
               state_in = perm_word;
            end
         end

         arx_aead_pkg::FSM_DONE: begin
            // hand the result over once the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               fsm_in       = arx_aead_pkg::FSM_IDLE;
               if (act_ff == arx_aead_pkg::ACT_FINALIZE) begin
                  rsp_lo_in    = tag_lo;
                  rsp_hi_in    = tag_hi;
                  rsp_match_in = (tag_lo == hold_lo_ff) && (tag_hi == hold_hi_ff);
               end else begin
                  rsp_lo_in    = pend_lo_ff;
                  rsp_hi_in    = pend_hi_ff;
                  rsp_match_in = 1'b0;
               end
            end
         end

         default: fsm_in = arx_aead_pkg::FSM_IDLE;
      endcase
   end

   // State register of the sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff <= arx_aead_pkg::FSM_IDLE;
      end else begin
         fsm_ff <= fsm_in;
      end
   end

   // Control state and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff       <= '0;
         state_ff     <= '0;
         ad_cnt_ff    <= '0;
         msg_cnt_ff   <= '0;
         round_ff     <= '0;
         upd_cnt_ff   <= '0;
         last_ff      <= '0;
         act_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_ff       <= key_in;
         state_ff     <= state_in;
         ad_cnt_ff    <= ad_cnt_in;
         msg_cnt_ff   <= msg_cnt_in;
         round_ff     <= round_in;
         upd_cnt_ff   <= upd_cnt_in;
         last_ff      <= last_in;
         act_ff       <= act_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      prev_ff      <= prev_in;
      hold_lo_ff   <= hold_lo_in;
      hold_hi_ff   <= hold_hi_in;
      pend_lo_ff   <= pend_lo_in;
      pend_hi_ff   <= pend_hi_in;
      rsp_lo_ff    <= rsp_lo_in;
      rsp_hi_ff    <= rsp_hi_in;
      rsp_match_ff <= rsp_match_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.result_lo = rsp_lo_ff;
   assign rsp_chan.result_hi = rsp_hi_ff;
   assign rsp_chan.tag_match = rsp_match_ff;

   // Checks
   a_round_idle: assert property (@(posedge clock) disable iff (reset)
      (fsm_ff == arx_aead_pkg::FSM_IDLE) |-> (round_ff == 2'd0))
      else $error("round counter not at zero while idle");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      (fsm_ff == arx_aead_pkg::FSM_IDLE && !accept) |=> $stable(state_ff))
      else $error("cipher state changed with no item in flight");

   a_cnt_hold: assert property (@(posedge clock) disable iff (reset)
      (fsm_ff != arx_aead_pkg::FSM_IDLE) |=> ($stable(ad_cnt_ff) && $stable(msg_cnt_ff)))
      else $error("byte counters changed during an update sequence");

   a_done_once: assert property (@(posedge clock) disable iff (reset)
      (fsm_ff == arx_aead_pkg::FSM_DONE && (!rsp_valid_ff || rsp_chan.ready))
      |=> (rsp_valid_ff && fsm_ff == arx_aead_pkg::FSM_IDLE))
      else $error("result not handed over on leaving the done state");

endmodule
